@@ src/pfa_pkg.sv @@
// Shared constants, codes and control types for the partition fit allocator.
// Used by pfa_ctrl, pfa_datapath and partition_fit_allocator_core.
`default_nettype none

package pfa_pkg;

   // Table geometry.
   localparam int PARTITIONS = 64;
   localparam int SIZE_W     = 16;
   localparam int IDX_W      = $clog2(PARTITIONS);
   localparam int CNT_W      = $clog2(PARTITIONS + 1);

   // Fixed field widths of the ports.
   localparam int ACTION_W   = 1;
   localparam int PINDEX_W   = 6;
   localparam int AMOUNT_W   = 16;
   localparam int MODE_W     = 2;
   localparam int PCOUNT_W   = 7;
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 7;
   localparam int TDATA_W    = 24;

   // Item kinds.
   localparam logic [ACTION_W-1:0] ACT_LOAD  = 1'b0;
   localparam logic [ACTION_W-1:0] ACT_ALLOC = 1'b1;

   // Fit modes.
   localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
   localparam logic [MODE_W-1:0] MODE_NEXT  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_BEST  = 2'd2;
   localparam logic [MODE_W-1:0] MODE_WORST = 2'd3;

   // Register indexes.
   localparam logic [CSR_ADDR_W-1:0] CSR_FIT_MODE   = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_PART_COUNT = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;     // latch the accepted word, set up a scan
      logic load_write;  // write a loaded free size
      logic scan_issue;  // read one table entry and step the scan
      logic commit;      // write back the chosen entry, form the result
      logic out_push;    // move the result into the output register
   } ctl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic scan_done;   // every entry in use has been read
      logic out_free;    // output register can take a word this cycle
   } dp_status_type;

endpackage

`default_nettype wire

@@ src/pfa_ctrl.sv @@
// Sequencing state machine of the partition fit allocator.
// Depends on pfa_pkg for the command and status structs.
`default_nettype none

module pfa_ctrl (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   input  wire logic [pfa_pkg::ACTION_W-1:0]    req_tuser,
   output logic                                 req_tready,
   input  wire pfa_pkg::dp_status_type          status,
   output pfa_pkg::ctl_cmd_type                 cmd
);
   import pfa_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_LOAD   = 3'd1;
   localparam logic [2:0] S_SCAN   = 3'd2;
   localparam logic [2:0] S_COMMIT = 3'd3;
   localparam logic [2:0] S_DONE   = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = (req_tuser == ACT_ALLOC) ? S_SCAN : S_LOAD;
            end
         end
         S_LOAD: begin
            cmd.load_write = 1'b1;
            state_in       = S_DONE;
         end
         S_SCAN: begin
            // The last read is compared at the edge that leaves this state.
            if (status.scan_done) begin
               state_in = S_COMMIT;
            end else begin
               cmd.scan_issue = 1'b1;
            end
         end
         S_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = S_DONE;
         end
         S_DONE: begin
            if (status.out_free) begin
               cmd.out_push = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

@@ src/pfa_datapath.sv @@
// Free-size table, scan compare, next-fit pointer and output register.
// Depends on pfa_pkg; driven by the commands of pfa_ctrl.
`default_nettype none

module pfa_datapath (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire pfa_pkg::ctl_cmd_type             cmd,
   output pfa_pkg::dp_status_type                status,
   input  wire logic [pfa_pkg::MODE_W-1:0]       fit_mode,
   input  wire logic [pfa_pkg::PCOUNT_W-1:0]     part_count,
   input  wire logic [pfa_pkg::PINDEX_W-1:0]     in_part_index,
   input  wire logic [pfa_pkg::AMOUNT_W-1:0]     in_amount,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic                                  out_ok,
   output logic [pfa_pkg::PINDEX_W-1:0]          out_chosen,
   output logic [pfa_pkg::AMOUNT_W-1:0]          out_remaining
);
   import pfa_pkg::*;

   logic [SIZE_W-1:0] mem [PARTITIONS];

   logic [CNT_W-1:0]    used_n;
   logic [PINDEX_W-1:0] pidx_ff;
   logic [SIZE_W-1:0]   amt_ff;
   logic [IDX_W-1:0]    addr_ff, addr_in;
   logic [CNT_W-1:0]    cnt_ff;
   logic [CNT_W-1:0]    addr_inc;
   logic [CNT_W-1:0]    best_inc;
   logic [IDX_W-1:0]    rover_ff;
   logic                rd_valid_ff;
   logic [SIZE_W-1:0]   rd_data_ff;
   logic [IDX_W-1:0]    rd_idx_ff;
   logic                found_ff;
   logic [IDX_W-1:0]    best_idx_ff;
   logic [SIZE_W-1:0]   best_val_ff;
   logic                take;
   logic                load_in_range;
   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr;
   logic [SIZE_W-1:0]   wr_data;
   logic [SIZE_W-1:0]   left;
   logic                res_ok_ff;
   logic [PINDEX_W-1:0] res_idx_ff;
   logic [AMOUNT_W-1:0] res_rem_ff;
   logic                rsp_valid_ff;
   logic [PINDEX_W-1:0] rsp_idx_ff;
   logic [AMOUNT_W-1:0] rsp_rem_ff;
   logic                rsp_ok_ff;

   // Entries in use, saturated at the table depth.
   always_comb begin
      if (32'(part_count) > PARTITIONS) begin
         used_n = CNT_W'(PARTITIONS);
      end else begin
         used_n = CNT_W'(part_count);
      end
   end

   assign status.scan_done = (cnt_ff >= used_n);
   assign status.out_free  = !rsp_valid_ff || rsp_tready;

   assign addr_inc = CNT_W'(addr_ff) + CNT_W'(1);
   assign best_inc = CNT_W'(best_idx_ff) + CNT_W'(1);
   assign addr_in  = (addr_inc >= used_n) ? '0 : IDX_W'(addr_inc);

   // Scan order is ascending except for the wrap, so a later hit only wins
   // when it is strictly better; ties stay with the earlier entry.
   always_comb begin
      take = 1'b0;
      if (rd_valid_ff && (rd_data_ff >= amt_ff)) begin
         if (!found_ff) begin
            take = 1'b1;
         end else if (fit_mode == MODE_BEST && rd_data_ff < best_val_ff) begin
            take = 1'b1;
         end else if (fit_mode == MODE_WORST && rd_data_ff > best_val_ff) begin
            take = 1'b1;
         end
      end
   end

   assign load_in_range = (32'(pidx_ff) < PARTITIONS);
   assign left          = best_val_ff - amt_ff;

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = best_idx_ff;
      wr_data = left;
      if (cmd.load_write) begin
         wr_en   = load_in_range;
         wr_addr = IDX_W'(pidx_ff);
         wr_data = amt_ff;
      end else if (cmd.commit) begin
         wr_en   = found_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.scan_issue) begin
         rd_data_ff <= mem[addr_ff];
      end
   end

   // Item and scan registers.
   always_ff @(posedge clock) begin
      rd_idx_ff <= addr_ff;
      if (cmd.capture) begin
         pidx_ff <= in_part_index;
         amt_ff  <= SIZE_W'(in_amount);
      end
      if (take) begin
         best_idx_ff <= rd_idx_ff;
         best_val_ff <= rd_data_ff;
      end
      if (cmd.load_write) begin
         res_idx_ff <= load_in_range ? pidx_ff : '0;
         res_rem_ff <= load_in_range ? AMOUNT_W'(amt_ff) : '0;
      end else if (cmd.commit) begin
         res_idx_ff <= found_ff ? PINDEX_W'(best_idx_ff) : '0;
         res_rem_ff <= found_ff ? AMOUNT_W'(left) : '0;
      end
      if (cmd.out_push) begin
         rsp_ok_ff  <= res_ok_ff;
         rsp_idx_ff <= res_idx_ff;
         rsp_rem_ff <= res_rem_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff      <= '0;
         cnt_ff       <= '0;
         rover_ff     <= '0;
         rd_valid_ff  <= 1'b0;
         found_ff     <= 1'b0;
         res_ok_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= cmd.scan_issue;
         if (cmd.capture) begin
            cnt_ff   <= '0;
            found_ff <= 1'b0;
            if (fit_mode == MODE_NEXT && CNT_W'(rover_ff) < used_n) begin
               addr_ff <= rover_ff;
            end else begin
               addr_ff <= '0;
            end
         end else begin
            if (cmd.scan_issue) begin
               cnt_ff  <= cnt_ff + CNT_W'(1);
               addr_ff <= addr_in;
            end
            if (take) begin
               found_ff <= 1'b1;
            end
         end
         if (cmd.load_write) begin
            res_ok_ff <= load_in_range;
            if (load_in_range) begin
               rover_ff <= '0;
            end
         end else if (cmd.commit) begin
            res_ok_ff <= found_ff;
            if (found_ff && fit_mode == MODE_NEXT) begin
               rover_ff <= (best_inc >= used_n) ? '0 : IDX_W'(best_inc);
            end
         end
         if (cmd.out_push) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid    = rsp_valid_ff;
   assign out_ok        = rsp_ok_ff;
   assign out_chosen    = rsp_idx_ff;
   assign out_remaining = rsp_rem_ff;

endmodule

`default_nettype wire

@@ src/partition_fit_allocator_core.sv @@
// Partition fit allocator top level: configuration registers, controller and datapath (pfa_pkg).
// A load word passes through the load and done states; an allocate word scans the N
// partitions in use, then passes through the commit and done states.
// A new word is taken only once the last one has moved to the output register; the single
// table read port scans one entry per cycle.
// Reset is synchronous: fit mode 0, count 1, next-fit pointer 0; the table is not cleared.
`default_nettype none

module partition_fit_allocator_core (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // Request channel.
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [pfa_pkg::TDATA_W-1:0]         req_tdata,  // part_index[5:0], amount[21:6], rest ignored
   input  wire logic [pfa_pkg::ACTION_W-1:0]        req_tuser,  // action[0]
   // Response channel.
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic [pfa_pkg::TDATA_W-1:0]              rsp_tdata,  // chosen[5:0], remaining[21:6], zero
   output logic                                     rsp_tuser,  // ok[0]
   // Configuration write port.
   input  wire logic                                csr_we,
   input  wire logic [pfa_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  wire logic [pfa_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import pfa_pkg::*;

   logic [MODE_W-1:0]   fit_mode_ff;
   logic [PCOUNT_W-1:0] part_count_ff;
   ctl_cmd_type         cmd;
   dp_status_type       status;
   logic                out_ok;
   logic [PINDEX_W-1:0] out_chosen;
   logic [AMOUNT_W-1:0] out_remaining;

   // Configuration registers. The user writes them only while the block is idle (not enforced
   // by the block itself), so the scan sees stable values for the whole of an item.
   always_ff @(posedge clock) begin
      if (reset) begin
         fit_mode_ff   <= MODE_FIRST;
         part_count_ff <= PCOUNT_W'(1);
      end else if (csr_we) begin
         case (csr_addr)
            CSR_FIT_MODE:   fit_mode_ff   <= MODE_W'(csr_wdata);
            CSR_PART_COUNT: part_count_ff <= PCOUNT_W'(csr_wdata);
            default: begin
            end
         endcase
      end
   end

   // The controller walks each word through load or scan-and-commit, then
   // hands the result to the output register in the datapath.
   pfa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // The datapath keeps the table, runs the fit compare on each read entry and
   // holds the result until the response side takes it.
   pfa_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .fit_mode      (fit_mode_ff),
      .part_count    (part_count_ff),
      .in_part_index (req_tdata[PINDEX_W-1:0]),
      .in_amount     (req_tdata[PINDEX_W +: AMOUNT_W]),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .out_ok        (out_ok),
      .out_chosen    (out_chosen),
      .out_remaining (out_remaining)
   );

   // Pack the response word, padding the top bits with zeros.
   assign rsp_tdata = {(TDATA_W - PINDEX_W - AMOUNT_W)'(0), out_remaining, out_chosen};
   assign rsp_tuser = out_ok;

endmodule

`default_nettype wire
